### design/ipvrf_pkg.sv
package ipvrf_pkg;

    localparam int unsigned WORD_W   = 16;
    localparam int unsigned ADDR_W   = 32;
    localparam int unsigned CNT_W    = 4;
    localparam int unsigned CFG_IDX_W = 2;

    // Word positions inside the fixed 20-byte header
    localparam logic [CNT_W-1:0] POS_VERSION  = 4'd0;
    localparam logic [CNT_W-1:0] POS_PROTOCOL = 4'd4;
    localparam logic [CNT_W-1:0] POS_CHECKSUM = 4'd5;
    localparam logic [CNT_W-1:0] POS_SRC_HI   = 4'd6;
    localparam logic [CNT_W-1:0] POS_SRC_LO   = 4'd7;
    localparam logic [CNT_W-1:0] POS_DST_HI   = 4'd8;
    localparam logic [CNT_W-1:0] POS_DST_LO   = 4'd9;
    localparam logic [CNT_W-1:0] HDR_WORDS    = 4'd10;

    localparam logic [3:0] IPV4_VERSION = 4'd4;
    localparam logic [7:0] PROTO_ICMP   = 8'd1;
    localparam logic [7:0] PROTO_TCP    = 8'd6;
    localparam logic [7:0] PROTO_UDP    = 8'd17;

    localparam logic [ADDR_W-1:0] ALL_ONES = 32'hFFFF_FFFF;

    localparam logic [CFG_IDX_W-1:0] REG_LOCAL_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NET_MASK      = 2'd1;

    typedef enum logic [1:0] {
        VERDICT_ACCEPT      = 2'd0,
        VERDICT_BAD_VERSION = 2'd1,
        VERDICT_BAD_CKSUM   = 2'd2,
        VERDICT_NOT_FOR_US  = 2'd3
    } verdict_t;

    typedef enum logic [1:0] {
        ROUTE_ICMP        = 2'd0,
        ROUTE_UDP         = 2'd1,
        ROUTE_TCP         = 2'd2,
        ROUTE_UNREACHABLE = 2'd3
    } route_t;

    // Finished header handed from the tracker to the classifier
    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] sum;
        logic [3:0]        version;
        logic [7:0]        protocol;
        logic [WORD_W-1:0] checksum;
        logic [ADDR_W-1:0] src;
        logic [ADDR_W-1:0] dst;
    } fin_t;

    // One's-complement add with end-around carry
    function automatic logic [WORD_W-1:0] ones_add(input logic [WORD_W-1:0] acc,
                                                   input logic [WORD_W-1:0] w);
        logic [WORD_W:0] s;
        s = {1'b0, acc} + {1'b0, w};
        return s[WORD_W] ? (s[WORD_W-1:0] + 16'd1) : s[WORD_W-1:0];
    endfunction

endpackage

### design/ipvrf_track.sv
module ipvrf_track
    import ipvrf_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              word_accept,
    input  logic [WORD_W-1:0] header_word,
    input  logic              first_word,
    input  logic              fin_take,
    output fin_t              fin
);

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [WORD_W-1:0] sum_reg, sum_next;
    logic [3:0]        version_reg, version_next;
    logic [7:0]        protocol_reg, protocol_next;
    logic [WORD_W-1:0] checksum_reg, checksum_next;
    logic [ADDR_W-1:0] src_reg, src_next;
    logic [ADDR_W-1:0] dst_reg, dst_next;
    fin_t              fin_reg, fin_next;

    logic              open_word;
    logic [CNT_W-1:0]  pos;
    logic [WORD_W-1:0] sum_base;
    logic [3:0]        version_base;
    logic [7:0]        protocol_base;
    logic [WORD_W-1:0] checksum_base;
    logic [ADDR_W-1:0] src_base;
    logic [ADDR_W-1:0] dst_base;

    always_comb begin
        // a start mark restarts the header; a bare word counts only mid-header
        open_word = first_word || ((count_reg != '0) && (count_reg < HDR_WORDS));
        pos       = first_word ? '0 : count_reg;

        sum_base      = first_word ? '0 : sum_reg;
        version_base  = first_word ? '0 : version_reg;
        protocol_base = first_word ? '0 : protocol_reg;
        checksum_base = first_word ? '0 : checksum_reg;
        src_base      = first_word ? '0 : src_reg;
        dst_base      = first_word ? '0 : dst_reg;

        count_next    = count_reg;
        sum_next      = sum_reg;
        version_next  = version_reg;
        protocol_next = protocol_reg;
        checksum_next = checksum_reg;
        src_next      = src_reg;
        dst_next      = dst_reg;

        if (word_accept && open_word) begin
            count_next    = pos + 4'd1;
            sum_next      = (pos != POS_CHECKSUM) ? ones_add(sum_base, header_word) : sum_base;
            version_next  = version_base;
            protocol_next = protocol_base;
            checksum_next = checksum_base;
            src_next      = src_base;
            dst_next      = dst_base;
            case (pos)
                POS_VERSION:  version_next  = header_word[15:12];
                POS_PROTOCOL: protocol_next = header_word[7:0];
                POS_CHECKSUM: checksum_next = header_word;
                POS_SRC_HI:   src_next      = {header_word, src_base[15:0]};
                POS_SRC_LO:   src_next      = {src_base[31:16], header_word};
                POS_DST_HI:   dst_next      = {header_word, dst_base[15:0]};
                POS_DST_LO:   dst_next      = {dst_base[31:16], header_word};
                default:      ;
            endcase
        end

        fin_next = fin_reg;
        if (fin_take) begin
            fin_next.valid = 1'b0;
        end
        if (word_accept && open_word && (pos == POS_DST_LO)) begin
            fin_next.valid    = 1'b1;
            fin_next.sum      = sum_next;
            fin_next.version  = version_next;
            fin_next.protocol = protocol_next;
            fin_next.checksum = checksum_next;
            fin_next.src      = src_next;
            fin_next.dst      = dst_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            sum_reg       <= '0;
            version_reg   <= '0;
            protocol_reg  <= '0;
            checksum_reg  <= '0;
            src_reg       <= '0;
            dst_reg       <= '0;
            fin_reg       <= '0;
        end else begin
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            version_reg   <= version_next;
            protocol_reg  <= protocol_next;
            checksum_reg  <= checksum_next;
            src_reg       <= src_next;
            dst_reg       <= dst_next;
            fin_reg       <= fin_next;
        end
    end

    assign fin = fin_reg;

endmodule

### design/ipvrf_classify.sv
module ipvrf_classify
    import ipvrf_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  fin_t              fin,
    input  logic [ADDR_W-1:0] local_address,
    input  logic [ADDR_W-1:0] net_mask,
    output logic              fin_take,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [71:0]       m_tdata,
    output logic [3:0]        m_tuser
);

    logic        valid_reg, valid_next;
    logic [71:0] data_reg;
    logic [3:0]  user_reg;

    verdict_t verdict;
    route_t   route;
    logic     for_us;

    always_comb begin
        for_us = (fin.dst == ALL_ONES) || (fin.dst == local_address)
              || (local_address == '0)
              || ((net_mask != '0) && ((fin.dst | net_mask) == ALL_ONES));

        route = ROUTE_ICMP;
        if (fin.version != IPV4_VERSION) begin
            verdict = VERDICT_BAD_VERSION;
        end else if (fin.checksum != ~fin.sum) begin
            verdict = VERDICT_BAD_CKSUM;
        end else if (!for_us) begin
            verdict = VERDICT_NOT_FOR_US;
        end else begin
            verdict = VERDICT_ACCEPT;
            case (fin.protocol)
                PROTO_ICMP: route = ROUTE_ICMP;
                PROTO_UDP:  route = ROUTE_UDP;
                PROTO_TCP:  route = ROUTE_TCP;
                default:    route = ROUTE_UNREACHABLE;
            endcase
        end
    end

    assign fin_take   = fin.valid && (!valid_reg || m_tready);
    assign valid_next = fin_take ? 1'b1 : (valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fin_take) begin
            data_reg <= {fin.dst, fin.src, fin.protocol};
            user_reg <= {route, verdict};
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;

endmodule

### design/ipv4_receive_filter.sv
// Throughput: one header word per cycle while s_tready is high; the tracker registers each
// word's update, the classifier registers the verdict, and a finished header waits in the
// stage between them. Reset: aresetn (synchronous, active low) clears the word count, the
// header state, both stage valids and the local address and subnet mask registers.
module ipv4_receive_filter
    import ipvrf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,    // [15:0] header_word
    input  logic [0:0]           s_tuser,    // [0] first_word

    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [71:0]          m_tdata,    // [7:0] protocol_number, [39:8] source_address,
                                             // [71:40] destination_address
    output logic [3:0]           m_tuser,    // [1:0] verdict, [3:2] route

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    logic [ADDR_W-1:0] local_address_reg;
    logic [ADDR_W-1:0] net_mask_reg;
    fin_t              fin;
    logic              fin_take;
    logic              word_accept;

    // Configuration writes land in the registers at the following clock edge; unknown indexes are dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            local_address_reg <= '0;
            net_mask_reg      <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_LOCAL_ADDRESS: local_address_reg <= cfg_data;
                REG_NET_MASK:      net_mask_reg      <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Take a beat unless a finished header is still parked and cannot move on
    assign s_tready    = !fin.valid || fin_take;
    assign word_accept = s_tvalid && s_tready;

    ipvrf_track u_track (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .word_accept (word_accept),
        .header_word (s_tdata),
        .first_word  (s_tuser[0]),
        .fin_take    (fin_take),
        .fin         (fin)
    );

    ipvrf_classify u_classify (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .fin           (fin),
        .local_address (local_address_reg),
        .net_mask      (net_mask_reg),
        .fin_take      (fin_take),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser)
    );

endmodule
